[rtl/core/hdplc_pkg.sv]
// Shared types and arithmetic helpers for the pixel layer compositor.
package hdplc_pkg;

  typedef logic [2:0][7:0]  rgb8_t;
  typedef logic [2:0][11:0] rgb12_t;
  typedef logic [2:0][15:0] rgb16_t;

  localparam logic [3:0]  BrightFull  = 4'd15;
  localparam logic [7:0]  AlphaOpaque = 8'hFF;
  localparam logic [7:0]  AlphaClear  = 8'h00;
  localparam logic [7:0]  ChanMax     = 8'hFF;
  localparam logic [11:0] Recip15     = 12'd2185;
  localparam logic [16:0] Recip255    = 17'd32897;

  function automatic logic [7:0] div15(input logic [11:0] p);
    logic [23:0] m;
    m = 24'(p) * 24'(Recip15);
    return m[22:15];
  endfunction

  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [32:0] m;
    m = 33'(p) * 33'(Recip255);
    return m[30:23];
  endfunction

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

endpackage

[rtl/core/hd_pixel_layer_compositor_top.sv]
// Pixel layer compositor: bottom and top premultiplied texels over a native colour.
// Each beat passes through five register stages; stage 5 is the output register.
// Throughput: one beat per cycle unless the output stalls; each stage holds one pixel
// and loads whenever it is empty or the stage after it moves on.
// Reset: rst clears all stage valid bits; datapath registers are not reset.
module hd_pixel_layer_compositor_top
  import hdplc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // native_color, bottom_texel, top_texel, math_operand, brightness, 5'b0
  input  logic [111:0] s_tdata,
  // bottom_present, top_in_range, math_enable, math_subtract, math_halve
  input  logic [4:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // pixel_out
  output logic [31:0]  m_tdata,
  // write_enable
  output logic [0:0]   m_tuser
);

  logic [23:0] in_native;
  logic [31:0] in_bot;
  logic [31:0] in_top;
  logic [14:0] in_op;
  logic [3:0]  in_br;

  assign in_native = s_tdata[23:0];
  assign in_bot    = s_tdata[55:24];
  assign in_top    = s_tdata[87:56];
  assign in_op     = s_tdata[102:88];
  assign in_br     = s_tdata[106:103];

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  assign en5      = !m_tvalid || m_tready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign s_tready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (en1) v1 <= s_tvalid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) m_tvalid <= v4;
    end
  end

  // stage 1: colour math, bottom brightness product, bottom blend product
  logic        s1_top_ok, s1_bot_use, s1_bot_full;
  rgb8_t       s1_bot_c, s1_tm, s1_native;
  rgb12_t      s1_pb;
  rgb16_t      s1_pbl;
  logic [3:0]  s1_br;
  logic [7:0]  s1_at;
  rgb8_t       s1_tm_next;
  rgb12_t      s1_pb_next;
  rgb16_t      s1_pbl_next;

  always_comb begin
    logic [7:0] c, m, inv;
    logic [8:0] sum;
    inv = ChanMax - in_bot[31:24];
    for (int i = 0; i < 3; i++) begin
      c = in_top[i*8 +: 8];
      m = widen5(in_op[(2-i)*5 +: 5]);
      sum = 9'(c) + 9'(m);
      s1_pb_next[i]  = 12'(in_bot[i*8 +: 8]) * 12'(in_br);
      s1_pbl_next[i] = 16'(in_native[i*8 +: 8]) * 16'(inv);
      if (s_tuser[3]) begin
        s1_tm_next[i] = (c > m) ? c - m : 8'd0;
      end else begin
        s1_tm_next[i] = sum[8] ? ChanMax : sum[7:0];
      end
      if (s_tuser[4]) s1_tm_next[i] = {1'b0, s1_tm_next[i][7:1]};
      if (!s_tuser[2]) s1_tm_next[i] = c;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_top_ok   <= s_tuser[1];
      s1_bot_use  <= s_tuser[0] && (in_bot[31:24] != AlphaClear);
      s1_bot_full <= in_bot[31:24] == AlphaOpaque;
      s1_bot_c    <= in_bot[23:0];
      s1_tm       <= s1_tm_next;
      s1_native   <= in_native;
      s1_pb       <= s1_pb_next;
      s1_pbl      <= s1_pbl_next;
      s1_br       <= in_br;
      s1_at       <= in_top[31:24];
    end
  end

  // stage 2: bottom brightness, bottom blend quotient, top brightness product
  logic        s2_top_ok, s2_bot_use, s2_bot_full;
  rgb8_t       s2_bd, s2_q1, s2_tm, s2_native;
  rgb12_t      s2_pt;
  logic [3:0]  s2_br;
  logic [7:0]  s2_at;

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int i = 0; i < 3; i++) begin
        s2_bd[i] <= (s1_br == BrightFull) ? s1_bot_c[i] : div15(s1_pb[i]);
        s2_q1[i] <= div255(s1_pbl[i]);
        s2_pt[i] <= 12'(s1_tm[i]) * 12'(s1_br);
      end
      s2_top_ok   <= s1_top_ok;
      s2_bot_use  <= s1_bot_use;
      s2_bot_full <= s1_bot_full;
      s2_tm       <= s1_tm;
      s2_native   <= s1_native;
      s2_br       <= s1_br;
      s2_at       <= s1_at;
    end
  end

  // stage 3: bottom composite, top brightness
  logic        s3_top_ok;
  rgb8_t       s3_res, s3_td;
  logic [7:0]  s3_at;

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int i = 0; i < 3; i++) begin
        if (!s2_bot_use) begin
          s3_res[i] <= s2_native[i];
        end else if (s2_bot_full) begin
          s3_res[i] <= s2_bd[i];
        end else begin
          s3_res[i] <= s2_bd[i] + s2_q1[i];
        end
        s3_td[i] <= (s2_br == BrightFull) ? s2_tm[i] : div15(s2_pt[i]);
      end
      s3_top_ok <= s2_top_ok;
      s3_at     <= s2_at;
    end
  end

  // stage 4: top blend product
  logic        s4_top_ok;
  rgb8_t       s4_res, s4_td;
  rgb16_t      s4_ptl;
  logic [7:0]  s4_at;

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int i = 0; i < 3; i++) begin
        s4_ptl[i] <= 16'(s3_res[i]) * 16'(ChanMax - s3_at);
      end
      s4_top_ok <= s3_top_ok;
      s4_res    <= s3_res;
      s4_td     <= s3_td;
      s4_at     <= s3_at;
    end
  end

  // stage 5: top composite into the output register
  rgb8_t out_rgb;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (s4_at == AlphaClear) begin
        out_rgb[i] = s4_res[i];
      end else if (s4_at == AlphaOpaque) begin
        out_rgb[i] = s4_td[i];
      end else begin
        out_rgb[i] = s4_td[i] + div255(s4_ptl[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      m_tdata <= s4_top_ok ? {AlphaOpaque, out_rgb} : 32'd0;
      m_tuser <= s4_top_ok;
    end
  end

endmodule

[rtl/core/hdplc_checker.sv]
// Port-level checks for the pixel layer compositor, bound to the top level.
module hdplc_checker
  import hdplc_pkg::*;
(
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [31:0]  m_tdata,
  input logic [0:0]   m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  a_no_write_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == 32'd0)
    else $error("unwritten pixel carries data");

  a_write_opaque: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[31:24] == AlphaOpaque)
    else $error("written pixel is not opaque");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with output empty");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind hd_pixel_layer_compositor_top hdplc_checker u_hdplc_checker (.*);
